[design/hsp_pkg.sv]
// Shared types and constants of the histogram specification block.
package hsp_pkg;

    localparam int LEVEL_BITS = 8;
    localparam int LEVELS     = 256;

    // Configuration register indexes
    localparam logic [2:0] REG_K1X = 3'd0;
    localparam logic [2:0] REG_K1Y = 3'd1;
    localparam logic [2:0] REG_K2X = 3'd2;
    localparam logic [2:0] REG_K2Y = 3'd3;
    localparam logic [2:0] REG_K3X = 3'd4;
    localparam logic [2:0] REG_K3Y = 3'd5;

    // Register reset values
    localparam logic [7:0] K1X_RST = 8'd60;
    localparam logic [7:0] K1Y_RST = 8'd200;
    localparam logic [7:0] K2X_RST = 8'd120;
    localparam logic [7:0] K2Y_RST = 8'd50;
    localparam logic [7:0] K3X_RST = 8'd190;
    localparam logic [7:0] K3Y_RST = 8'd200;

    localparam logic [7:0] MAX_LEVEL = 8'd255;

    // Curve knees
    typedef struct packed {
        logic [7:0] k1x;
        logic [7:0] k1y;
        logic [7:0] k2x;
        logic [7:0] k2y;
        logic [7:0] k3x;
        logic [7:0] k3y;
    } t_knees;

    // Histogram read and clear from the map builder
    typedef struct packed {
        logic       rd;
        logic       clr;
        logic [7:0] addr;
    } t_hist_cmd;

    // Final map write from the map builder
    typedef struct packed {
        logic       we;
        logic [7:0] addr;
        logic [7:0] data;
    } t_fin_wr;
endpackage

[design/hsp_div.sv]
// Restoring divider with an 8-bit quotient that saturates at 255.
module hsp_div #(
    parameter int NW = 37,
    parameter int DW = 21
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [7:0]    o_quo
);

    logic          r_busy;
    logic          r_done;
    logic [2:0]    r_cnt;
    logic [NW-1:0] r_rem;
    logic [NW-1:0] r_dsh;
    logic [7:0]    r_q;
    logic          ge;
    logic          ovf;

    assign ge     = (r_rem >= r_dsh);
    // quotient above 8 bits: clamp
    assign ovf    = (i_num >= NW'({i_den, 8'h00}));
    assign o_done = r_done;
    assign o_quo  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (ovf) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_cnt == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= NW'({i_den, 7'h00});
            r_cnt <= 3'd7;
            r_q   <= ovf ? 8'hFF : 8'h00;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[6:0], ge};
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - 3'd1;
        end
    end

endmodule

[design/hsp_build.sv]
// Map builder: source map, target curve and map, nearest-level final map.
module hsp_build #(
    parameter int PIXEL_COUNT_BITS = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  hsp_pkg::t_knees             i_knees,
    input  logic [PIXEL_COUNT_BITS:0]   i_total,
    output hsp_pkg::t_hist_cmd          o_hcmd,
    input  logic [PIXEL_COUNT_BITS:0]   i_hrd,
    output hsp_pkg::t_fin_wr            o_fwr,
    output logic                        o_busy,
    output logic                        o_done
);
    import hsp_pkg::*;

    localparam int HW = PIXEL_COUNT_BITS + 1;
    localparam int CW = PIXEL_COUNT_BITS + 9;
    localparam int DW = (HW > 16) ? HW : 16;
    localparam int NW = CW + 8;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SRC_RD  = 4'd1;
    localparam logic [3:0] S_SRC_ACC = 4'd2;
    localparam logic [3:0] S_SRC_DIV = 4'd3;
    localparam logic [3:0] S_SRC_WT  = 4'd4;
    localparam logic [3:0] S_CRV_SET = 4'd5;
    localparam logic [3:0] S_CRV_DIV = 4'd6;
    localparam logic [3:0] S_CRV_WT  = 4'd7;
    localparam logic [3:0] S_CRV_WR  = 4'd8;
    localparam logic [3:0] S_TGT_RD  = 4'd9;
    localparam logic [3:0] S_TGT_ACC = 4'd10;
    localparam logic [3:0] S_TGT_DIV = 4'd11;
    localparam logic [3:0] S_TGT_WT  = 4'd12;
    localparam logic [3:0] S_TGT_WR  = 4'd13;
    localparam logic [3:0] S_FM_SRC  = 4'd14;
    localparam logic [3:0] S_FM_LOOP = 4'd15;

    logic [3:0]    r_state;
    logic          r_fm_cmp;   // in the final-map loop: 0 issue read, 1 compare
    logic          r_fm_s;     // in the final-map loop: source value arriving
    logic [7:0]    r_k;
    logic [7:0]    r_j;
    logic [7:0]    r_p;
    logic [7:0]    r_best;
    logic [8:0]    r_bestd;
    logic [7:0]    r_s;
    logic [CW-1:0] r_cum;
    logic [15:0]   r_ctotal;
    logic [15:0]   r_ccum;
    logic [15:0]   r_cnum;
    logic [7:0]    r_cden;
    logic          r_cneg;
    logic [7:0]    r_cy0;
    logic [7:0]    r_val;

    logic [7:0] src_mem [LEVELS];
    logic [7:0] tgt_mem [LEVELS];
    logic [7:0] r_src_rd;
    logic [7:0] r_tgt_rd;

    // divider
    logic          div_start;
    logic [NW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic          div_done;
    logic [7:0]    div_quo;

    hsp_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        div_start = 1'b0;
        div_num   = NW'(r_cnum);
        div_den   = DW'(r_cden);
        unique case (r_state)
            S_SRC_DIV: begin
                div_start = 1'b1;
                div_num   = NW'({r_cum, 8'h00}) - NW'(r_cum);
                div_den   = DW'(i_total);
            end
            S_CRV_DIV: begin
                div_start = 1'b1;
            end
            S_TGT_DIV: begin
                div_start = 1'b1;
                div_num   = NW'({r_ccum, 8'h00}) - NW'(r_ccum);
                div_den   = DW'(r_ctotal);
            end
            default: begin
            end
        endcase
    end

    // curve run selection for level r_k
    logic [7:0]  seg_x0, seg_y0, seg_xe, seg_ye, seg_den, seg_dx, seg_mag;
    logic        seg_neg;
    logic [15:0] seg_prod;

    always_comb begin
        if (r_k <= i_knees.k1x) begin
            seg_x0 = 8'd0;        seg_y0 = 8'd0;
            seg_xe = i_knees.k1x; seg_ye = i_knees.k1y;
        end else if (r_k <= i_knees.k2x) begin
            seg_x0 = i_knees.k1x; seg_y0 = i_knees.k1y;
            seg_xe = i_knees.k2x; seg_ye = i_knees.k2y;
        end else if (r_k <= i_knees.k3x) begin
            seg_x0 = i_knees.k2x; seg_y0 = i_knees.k2y;
            seg_xe = i_knees.k3x; seg_ye = i_knees.k3y;
        end else begin
            seg_x0 = i_knees.k3x; seg_y0 = i_knees.k3y;
            seg_xe = MAX_LEVEL;   seg_ye = 8'd0;
        end
        seg_den  = seg_xe - seg_x0;
        seg_dx   = r_k - seg_x0;
        seg_neg  = (seg_ye < seg_y0);
        seg_mag  = seg_neg ? (seg_y0 - seg_ye) : (seg_ye - seg_y0);
        seg_prod = seg_mag * seg_dx;
    end

    // final-map compare
    logic [8:0] fm_d;
    logic       fm_better;
    logic [7:0] fm_nbest;
    logic       fm_stop;

    always_comb begin
        fm_d      = (r_s >= r_tgt_rd) ? {1'b0, r_s - r_tgt_rd} : {1'b0, r_tgt_rd - r_s};
        fm_better = (fm_d < r_bestd);
        fm_nbest  = fm_better ? r_j : r_best;
        fm_stop   = (r_tgt_rd >= r_s) || (r_j == MAX_LEVEL);
    end

    logic in_fm_cmp;
    assign in_fm_cmp = (r_state == S_FM_LOOP) && r_fm_cmp && !r_fm_s;

    // histogram read and clear during the source pass, final-map write in the scan
    always_comb begin
        o_hcmd.rd   = (r_state == S_SRC_RD);
        o_hcmd.clr  = (r_state == S_SRC_RD);
        o_hcmd.addr = r_k;
        o_fwr.we    = in_fm_cmp && fm_stop;
        o_fwr.addr  = r_k;
        o_fwr.data  = fm_nbest;
    end

    assign o_busy = (r_state != S_IDLE);

    // source and target memories
    logic       src_we, tgt_we, tgt_re;
    logic [7:0] tgt_addr;

    assign src_we   = (r_state == S_SRC_WT) && div_done;
    assign tgt_we   = (r_state == S_CRV_WR) || (r_state == S_TGT_WR);
    assign tgt_re   = (r_state == S_TGT_RD) ||
                      ((r_state == S_FM_LOOP) && !r_fm_cmp && !r_fm_s);
    assign tgt_addr = (r_state == S_FM_LOOP) ? r_j : r_k;

    always_ff @(posedge i_clk) begin
        if (src_we) begin
            src_mem[r_k] <= div_quo;
        end
        if (r_state == S_FM_SRC) begin
            r_src_rd <= src_mem[r_k];
        end
        if (tgt_we) begin
            tgt_mem[r_k] <= r_val;
        end
        if (tgt_re) begin
            r_tgt_rd <= tgt_mem[tgt_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_SRC_RD;
                    end
                end
                S_SRC_RD:  r_state <= S_SRC_ACC;
                S_SRC_ACC: r_state <= S_SRC_DIV;
                S_SRC_DIV: r_state <= S_SRC_WT;
                S_SRC_WT: begin
                    if (div_done) begin
                        r_state <= (r_k == MAX_LEVEL) ? S_CRV_SET : S_SRC_RD;
                    end
                end
                S_CRV_SET: r_state <= (seg_den == 8'd0) ? S_CRV_WR : S_CRV_DIV;
                S_CRV_DIV: r_state <= S_CRV_WT;
                S_CRV_WT: begin
                    if (div_done) begin
                        r_state <= S_CRV_WR;
                    end
                end
                S_CRV_WR: r_state <= (r_k == MAX_LEVEL) ? S_TGT_RD : S_CRV_SET;
                S_TGT_RD: r_state <= S_TGT_ACC;
                S_TGT_ACC: r_state <= (r_ctotal == 16'd0) ? S_TGT_WR : S_TGT_DIV;
                S_TGT_DIV: r_state <= S_TGT_WT;
                S_TGT_WT: begin
                    if (div_done) begin
                        r_state <= S_TGT_WR;
                    end
                end
                S_TGT_WR: r_state <= (r_k == MAX_LEVEL) ? S_FM_SRC : S_TGT_RD;
                S_FM_SRC: r_state <= S_FM_LOOP;
                S_FM_LOOP: begin
                    if (in_fm_cmp && fm_stop) begin
                        if (r_k == MAX_LEVEL) begin
                            r_state <= S_IDLE;
                            o_done  <= 1'b1;
                        end else begin
                            r_state <= S_FM_SRC;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_k   <= 8'd0;
                r_cum <= '0;
            end
            S_SRC_ACC: r_cum <= r_cum + CW'(i_hrd);
            S_SRC_WT: begin
                if (div_done) begin
                    r_k <= r_k + 8'd1;
                    if (r_k == MAX_LEVEL) begin
                        r_ctotal <= 16'd0;
                    end
                end
            end
            S_CRV_SET: begin
                r_cnum <= seg_prod;
                r_cden <= seg_den;
                r_cneg <= seg_neg;
                r_cy0  <= seg_y0;
                r_val  <= seg_ye;
            end
            S_CRV_WT: begin
                if (div_done) begin
                    r_val <= r_cneg ? (r_cy0 - div_quo) : (r_cy0 + div_quo);
                end
            end
            S_CRV_WR: begin
                r_ctotal <= r_ctotal + 16'(r_val);
                r_k      <= r_k + 8'd1;
                r_ccum   <= 16'd0;
            end
            S_TGT_ACC: begin
                r_ccum <= r_ccum + 16'(r_tgt_rd);
                r_val  <= 8'd0;
            end
            S_TGT_WT: begin
                if (div_done) begin
                    r_val <= div_quo;
                end
            end
            S_TGT_WR: begin
                r_k <= r_k + 8'd1;
                r_p <= 8'd0;
            end
            S_FM_SRC: begin
                r_fm_s   <= 1'b1;
                r_fm_cmp <= 1'b0;
            end
            S_FM_LOOP: begin
                if (r_fm_s) begin
                    // source level arrives: restart the scan at the last answer
                    r_fm_s  <= 1'b0;
                    r_s     <= r_src_rd;
                    r_j     <= r_p;
                    r_bestd <= 9'h1FF;
                end else if (!r_fm_cmp) begin
                    r_fm_cmp <= 1'b1;
                end else begin
                    r_fm_cmp <= 1'b0;
                    r_best   <= fm_nbest;
                    if (fm_better) begin
                        r_bestd <= fm_d;
                    end
                    if (fm_stop) begin
                        r_p <= fm_nbest;
                        r_k <= r_k + 8'd1;
                    end else begin
                        r_j <= r_j + 8'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[design/histogram_specification_piecewise.sv]
// Top level of the histogram specification block: count, map and control.
//
//  channel    direction  handshake                     payload
//  s_axis     in         i_s_axis_tvalid/o_..._tready  tuser opcode, tdata pixel, tlast last
//  m_axis     out        o_m_axis_tvalid/i_..._tready  tdata mapped_pixel
//  cfg        in         i_cfg_we                      i_cfg_addr index, i_cfg_wdata value
//
// Count and map pixels are taken one per cycle while the block is not
// clearing, building a map or held by a full output. A count pixel updates
// its bin with a read-modify-write, forwarding the previous write when the
// same bin follows. The last count pixel starts the map build, which holds
// the input off until it is done; its length is set by the iterative 8-bit
// divider (three divide passes over 256 levels) and the nearest-level scan.
// After reset a clearing pass over all 256 levels zeroes the histogram and
// the final map before input is taken. The output register and one read
// stage let a new request in while a result waits.
module histogram_specification_piecewise #(
    parameter int PIXEL_COUNT_BITS = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] pixel
    input  logic       i_s_axis_tuser,   // [0] opcode
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] mapped_pixel
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wdata
);
    import hsp_pkg::*;

    localparam int HW = PIXEL_COUNT_BITS + 1;
    localparam logic [HW-1:0] CAP = HW'(1) << PIXEL_COUNT_BITS;

    t_knees r_knees;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knees.k1x <= K1X_RST;
            r_knees.k1y <= K1Y_RST;
            r_knees.k2x <= K2X_RST;
            r_knees.k2y <= K2Y_RST;
            r_knees.k3x <= K3X_RST;
            r_knees.k3y <= K3Y_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_K1X: r_knees.k1x <= i_cfg_wdata;
                REG_K1Y: r_knees.k1y <= i_cfg_wdata;
                REG_K2X: r_knees.k2x <= i_cfg_wdata;
                REG_K2Y: r_knees.k2y <= i_cfg_wdata;
                REG_K3X: r_knees.k3x <= i_cfg_wdata;
                REG_K3Y: r_knees.k3y <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // control state
    logic          r_clearing;
    logic [7:0]    r_clr_cnt;
    logic          r_bpend;
    logic          r_c1_valid;
    logic [7:0]    r_c1_addr;
    logic          r_cw_valid;
    logic [7:0]    r_cw_addr;
    logic [HW-1:0] r_cw_data;
    logic [HW-1:0] r_total;
    logic          r_mvalid;
    logic          r_ov;
    logic [7:0]    r_odata;

    t_hist_cmd     hcmd;
    t_fin_wr       fwr;
    logic          b_busy;
    logic          b_done;
    logic          b_start;
    logic [HW-1:0] r_hrd;
    logic [7:0]    r_fdata;

    logic          adv;
    logic          accept;
    logic          acc_cnt;
    logic          acc_map;
    logic [HW-1:0] cnt_old;
    logic [HW-1:0] cnt_new;

    // advance the read stage into the output register when it has room
    assign adv             = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = !r_clearing && !r_bpend && !b_busy && (!r_mvalid || adv);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign acc_cnt         = accept && !i_s_axis_tuser;
    assign acc_map         = accept && i_s_axis_tuser;
    assign b_start         = r_bpend && !r_c1_valid;

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_odata;

    // forward the bin written at the edge of this stage's read
    assign cnt_old = (r_cw_valid && (r_cw_addr == r_c1_addr)) ? r_cw_data : r_hrd;
    assign cnt_new = (cnt_old < CAP) ? (cnt_old + HW'(1)) : cnt_old;

    // histogram memory
    logic [HW-1:0] hist_mem [LEVELS];
    logic          hist_we;
    logic [7:0]    hist_wa;
    logic [HW-1:0] hist_wd;
    logic          hist_re;
    logic [7:0]    hist_ra;

    always_comb begin
        hist_we = 1'b0;
        hist_wa = r_c1_addr;
        hist_wd = cnt_new;
        if (r_clearing) begin
            hist_we = 1'b1;
            hist_wa = r_clr_cnt;
            hist_wd = '0;
        end else if (hcmd.clr) begin
            hist_we = 1'b1;
            hist_wa = hcmd.addr;
            hist_wd = '0;
        end else if (r_c1_valid) begin
            hist_we = 1'b1;
        end
        hist_re = acc_cnt || hcmd.rd;
        hist_ra = b_busy ? hcmd.addr : i_s_axis_tdata;
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            hist_mem[hist_wa] <= hist_wd;
        end
        if (hist_re) begin
            r_hrd <= hist_mem[hist_ra];
        end
    end

    // final map memory
    logic [7:0] fin_mem [LEVELS];

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            fin_mem[r_clr_cnt] <= 8'd0;
        end else if (fwr.we) begin
            fin_mem[fwr.addr] <= fwr.data;
        end
        if (acc_map) begin
            r_fdata <= fin_mem[i_s_axis_tdata];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= 8'd0;
            r_bpend    <= 1'b0;
            r_c1_valid <= 1'b0;
            r_cw_valid <= 1'b0;
            r_total    <= '0;
            r_mvalid   <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 8'd1;
                if (r_clr_cnt == MAX_LEVEL) begin
                    r_clearing <= 1'b0;
                end
            end
            r_c1_valid <= acc_cnt;
            r_cw_valid <= r_c1_valid;
            if (acc_cnt && i_s_axis_tlast) begin
                r_bpend <= 1'b1;
            end else if (b_start) begin
                r_bpend <= 1'b0;
            end
            // restart the count, keeping a pixel taken in the done cycle
            if (b_done) begin
                r_total <= acc_cnt ? HW'(1) : '0;
            end else if (acc_cnt && (r_total < CAP)) begin
                r_total <= r_total + HW'(1);
            end
            // read stage and output register
            if (adv) begin
                r_ov <= r_mvalid;
            end
            if (acc_map) begin
                r_mvalid <= 1'b1;
            end else if (adv) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc_cnt) begin
            r_c1_addr <= i_s_axis_tdata;
        end
        if (r_c1_valid) begin
            r_cw_addr <= r_c1_addr;
            r_cw_data <= cnt_new;
        end
        if (adv && r_mvalid) begin
            r_odata <= r_fdata;
        end
    end

    hsp_build #(.PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)) u_build (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (b_start),
        .i_knees (r_knees),
        .i_total (r_total),
        .o_hcmd  (hcmd),
        .i_hrd   (r_hrd),
        .o_fwr   (fwr),
        .o_busy  (b_busy),
        .o_done  (b_done)
    );

endmodule

[sim/tb_histogram_specification_piecewise.sv]
// Testbench for the piecewise histogram specification block: self-predicting stream checks.
`timescale 1ns / 100ps

module tb_histogram_specification_piecewise;
    import hsp_pkg::*;

    localparam int          CLK_HALF     = 6;
    localparam int          CYCLE_LIMIT  = 2_000_000;
    // The map build holds the input off; give it margin before touching the
    // knee registers.
    localparam int          BUILD_SETTLE = 16_000;
    localparam longint      COUNT_CAP    = longint'(1) << 20;
    localparam logic        OP_COUNT     = 1'b0;
    localparam logic        OP_MAP       = 1'b1;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata  = '0;    // [7:0] pixel
    logic       i_s_axis_tuser  = 1'b0;  // [0] opcode
    logic       i_s_axis_tlast  = 1'b0;
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;          // [7:0] mapped_pixel
    logic       i_cfg_we        = 1'b0;
    logic [2:0] i_cfg_addr      = '0;
    logic [7:0] i_cfg_wdata     = '0;

    histogram_specification_piecewise u_dut (.*);

    always #(CLK_HALF) i_clk = ~i_clk;

    // Predictor state: knees, histogram and the live lookup table.
    logic [7:0]   knee_x [1:3];
    logic [7:0]   knee_y [1:3];
    longint       bin_count [LEVELS];
    longint       pixel_sum;
    logic [7:0]   lut [LEVELS];
    logic [7:0]   mapped_q [$];

    int  fail_count;
    int  requests_sent;
    int  results_seen;
    int  frames_built;
    int  cycle_count;
    bit  steady;        // suppress random idling on both sides
    int  rx_hold;       // receiver hold-off cycles still to serve

    function automatic int lerp(int x0, int y0, int x1, int y1, int i);
        if (x1 == x0) return y0;
        return y0 + (y1 - y0) * (i - x0) / (x1 - x0);
    endfunction

    // Rebuild the lookup table from the histogram and the knee curve.
    function automatic void build_lut();
        int         curve [LEVELS];
        logic [7:0] src [LEVELS];
        logic [7:0] tgt [LEVELS];
        longint     cum;
        int         x1, y1, x2, y2, x3, y3, i, ctot, ccum, best, bestd, d;
        longint     q;
        x1 = knee_x[1]; y1 = knee_y[1];
        x2 = knee_x[2]; y2 = knee_y[2];
        x3 = knee_x[3]; y3 = knee_y[3];
        cum = 0;
        for (int k = 0; k < LEVELS; k++) begin
            cum += bin_count[k];
            q = (pixel_sum != 0) ? cum * 255 / pixel_sum : 0;
            src[k] = (q > 255) ? 8'd255 : q[7:0];
        end
        i = 0;
        for (; i <= x1; i++) curve[i] = (x1 > 0) ? y1 * i / x1 : y1;
        for (; i <= x2; i++) curve[i] = lerp(x1, y1, x2, y2, i);
        for (; i <= x3; i++) curve[i] = lerp(x2, y2, x3, y3, i);
        for (; i < LEVELS; i++) curve[i] = lerp(x3, y3, 255, 0, i);
        ctot = 0;
        for (int k = 0; k < LEVELS; k++) ctot += curve[k] & 255;
        ccum = 0;
        for (int k = 0; k < LEVELS; k++) begin
            ccum += curve[k] & 255;
            tgt[k] = (ctot != 0) ? 8'(ccum * 255 / ctot) : 8'd0;
        end
        // Nearest cumulative level, lowest index on ties.
        for (int k = 0; k < LEVELS; k++) begin
            best  = 0;
            bestd = 1000;
            for (int j = 0; j < LEVELS; j++) begin
                d = int'(src[k]) - int'(tgt[j]);
                if (d < 0) d = -d;
                if (d < bestd) begin
                    bestd = d;
                    best  = j;
                end
            end
            lut[k] = 8'(best);
        end
    endfunction

    // Apply one accepted request to the predictor.
    function automatic void predict_request(logic op, logic [7:0] px, logic lst);
        if (op == OP_MAP) begin
            mapped_q.push_back(lut[px]);
            return;
        end
        if (bin_count[px] < COUNT_CAP) bin_count[px]++;
        if (pixel_sum < COUNT_CAP) pixel_sum++;
        if (lst) begin
            build_lut();
            frames_built++;
            foreach (bin_count[k]) bin_count[k] = 0;
            pixel_sum = 0;
        end
    endfunction

    // Offer one request and hold it until the block takes it.
    task automatic send_pixel(logic op, logic [7:0] px, logic lst);
        if (!steady && $urandom_range(99) < 12) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= px;
        i_s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_request(op, px, lst);
        requests_sent++;
    endtask

    // Drain all results, then let a map build with no result finish.
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        wait (mapped_q.size() == 0);
        repeat (BUILD_SETTLE) @(posedge i_clk);
    endtask

    task automatic set_knees(logic [7:0] x1, logic [7:0] y1, logic [7:0] x2,
                             logic [7:0] y2, logic [7:0] x3, logic [7:0] y3);
        logic [2:0] idx  [6];
        logic [7:0] vals [6];
        wait_idle();
        idx  = '{REG_K1X, REG_K1Y, REG_K2X, REG_K2Y, REG_K3X, REG_K3Y};
        vals = '{x1, y1, x2, y2, x3, y3};
        for (int k = 0; k < 6; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= idx[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        knee_x[1] = x1; knee_y[1] = y1;
        knee_x[2] = x2; knee_y[2] = y2;
        knee_x[3] = x3; knee_y[3] = y3;
    endtask

    // Count a frame of n random pixels (last on the final one).
    task automatic count_frame(int n, int lo, int hi);
        for (int k = 0; k < n; k++)
            send_pixel(OP_COUNT, 8'($urandom_range(lo, hi)), k == n - 1);
    endtask

    task automatic map_levels(int n);
        for (int k = 0; k < n; k++) send_pixel(OP_MAP, 8'($urandom_range(255)), 1'b0);
    endtask

    // Map through the reset table, including a stray last on a map request.
    task automatic test_reset_table();
        send_pixel(OP_MAP, 8'd0, 1'b0);
        send_pixel(OP_MAP, 8'd255, 1'b0);
        send_pixel(OP_MAP, 8'hA5, 1'b1);
    endtask

    // One-pixel frame and a frame at both ends of the grey range.
    task automatic test_tiny_frames();
        send_pixel(OP_COUNT, 8'd0, 1'b1);
        send_pixel(OP_MAP, 8'd0, 1'b0);
        send_pixel(OP_MAP, 8'd255, 1'b0);
        send_pixel(OP_COUNT, 8'd255, 1'b0);
        send_pixel(OP_COUNT, 8'd255, 1'b0);
        send_pixel(OP_COUNT, 8'd0, 1'b1);
        send_pixel(OP_MAP, 8'd0, 1'b0);
        send_pixel(OP_MAP, 8'd128, 1'b0);
        send_pixel(OP_MAP, 8'd255, 1'b1);
        send_pixel(OP_MAP, 8'h5A, 1'b0);
    endtask

    // Knee corners: flat zero curve, full-height curve, unordered knees.
    task automatic test_knee_extremes();
        set_knees(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        count_frame(5, 0, 255);
        map_levels(4);
        set_knees(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        count_frame(5, 0, 255);
        map_levels(4);
        set_knees(8'd200, 8'd10, 8'd50, 8'd255, 8'd100, 8'd0);
        count_frame(5, 0, 255);
        map_levels(4);
    endtask

    // Stall the receiver while map requests keep coming, so the input backs up.
    task automatic test_backpressure();
        count_frame(12, 40, 200);
        steady  = 1'b1;
        // first map request waits out the build, then the hold starts
        map_levels(1);
        rx_hold = 300;
        map_levels(40);
        steady  = 1'b0;
    endtask

    // Mostly well-formed frames with random knees; some bursts run without idling.
    task automatic test_random_frames(int target);
        int n, lo, hi;
        while (requests_sent < target) begin
            if ($urandom_range(5) == 0)
                set_knees(8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom));
            steady = ($urandom_range(3) == 0);
            lo = $urandom_range(255);
            hi = $urandom_range(lo, 255);
            if ($urandom_range(3) == 0) begin
                lo = 0;
                hi = 255;
            end
            n = $urandom_range(1, 40);
            count_frame(n, lo, hi);
            n = $urandom_range(20, 80);
            for (int k = 0; k < n; k++)
                send_pixel(OP_MAP, 8'($urandom), $urandom_range(9) == 0);
        end
        steady = 1'b0;
    endtask

    // Result checker and receiver idling.
    always @(posedge i_clk) begin
        logic [7:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (mapped_q.size() == 0) begin
                $error("mapped_pixel: unexpected result %0d", o_m_axis_tdata);
                fail_count++;
            end else begin
                want = mapped_q.pop_front();
                if (o_m_axis_tdata !== want) begin
                    $error("mapped_pixel: expected %0d, got %0d", want, o_m_axis_tdata);
                    fail_count++;
                end
            end
        end
        if (rx_hold > 0) begin
            i_m_axis_tready <= 1'b0;
            rx_hold--;
        end else begin
            i_m_axis_tready <= steady || ($urandom_range(99) >= 12);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        knee_x[1] = K1X_RST; knee_y[1] = K1Y_RST;
        knee_x[2] = K2X_RST; knee_y[2] = K2Y_RST;
        knee_x[3] = K3X_RST; knee_y[3] = K3Y_RST;
        foreach (bin_count[k]) bin_count[k] = 0;
        foreach (lut[k]) lut[k] = '0;
        pixel_sum = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_table();
        test_tiny_frames();
        test_knee_extremes();
        set_knees(K1X_RST, K1Y_RST, K2X_RST, K2Y_RST, K3X_RST, K3Y_RST);
        test_backpressure();
        test_random_frames(1500);

        i_s_axis_tvalid <= 1'b0;
        wait (mapped_q.size() == 0);
        repeat (50) @(posedge i_clk);
        $display("covered %0d requests, %0d mapped results, %0d map builds",
                 requests_sent, results_seen, frames_built);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[histogram_specification_piecewise.f]
design/hsp_pkg.sv
design/hsp_div.sv
design/hsp_build.sv
design/histogram_specification_piecewise.sv
sim/tb_histogram_specification_piecewise.sv
